### hw/rtl/sbi_pkg.sv
// Shared types, breakpoint ROM and segment constants of the sensor breakpoint interpolator.
// Used by every module of the block; depends on nothing.
package sbi_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int LEVEL_BITS   = 8;
   localparam int TABLE_POINTS = 14;
   localparam int NUM_SEGS     = TABLE_POINTS - 1;
   localparam int SEG_W        = $clog2(NUM_SEGS);
   localparam int LIMIT_BITS   = 12;

   // Product of a level step and a sample offset.
   localparam int PROD_W       = LEVEL_BITS + SAMPLE_BITS;
   // Reciprocal scaling: exact floor division for products below 2**PROD_W
   // as long as every span stays below 2**(RECIP_SHIFT - PROD_W).
   localparam int RECIP_SHIFT  = 32;
   localparam int RECIP_W      = 27;
   localparam int SCALED_W     = PROD_W + RECIP_W;

   localparam int QUEUE_DEPTH  = 2;

   localparam logic [LIMIT_BITS-1:0] HIGH_LIMIT_RESET = 12'd3300;
   localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET  = 12'd1000;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL       = 8'd255;
   localparam logic [LEVEL_BITS-1:0] LEVEL_EMPTY      = 8'd0;

   typedef enum logic [1:0] {
      FAULT_NONE       = 2'd0,
      FAULT_SHORT_LOW  = 2'd1,
      FAULT_SHORT_HIGH = 2'd2
   } fault_type;

   typedef enum logic [0:0] {
      CSR_FAULT_HIGH_LIMIT = 1'b0,
      CSR_FAULT_LOW_LIMIT  = 1'b1
   } csr_index_type;

   localparam logic [SAMPLE_BITS-1:0] ROM_X [TABLE_POINTS] = '{
      12'd3000, 12'd2690, 12'd2652, 12'd2604, 12'd2507, 12'd2434, 12'd2339,
      12'd2201, 12'd2074, 12'd1888, 12'd1634, 12'd1337, 12'd1182, 12'd1000
   };
   localparam logic [LEVEL_BITS-1:0] ROM_Y [TABLE_POINTS] = '{
      8'd0, 8'd0, 8'd10, 8'd20, 8'd39, 8'd59, 8'd92,
      8'd128, 8'd163, 8'd198, 8'd221, 8'd241, 8'd255, 8'd255
   };

   // One more than floor(2**RECIP_SHIFT / span) for each segment.
   localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[0]  - ROM_X[1])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[1]  - ROM_X[2])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[2]  - ROM_X[3])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[3]  - ROM_X[4])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[4]  - ROM_X[5])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[5]  - ROM_X[6])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[6]  - ROM_X[7])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[7]  - ROM_X[8])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[8]  - ROM_X[9])  + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[9]  - ROM_X[10]) + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[10] - ROM_X[11]) + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[11] - ROM_X[12]) + 64'd1),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (ROM_X[12] - ROM_X[13]) + 64'd1)
   };

   // One classified word handed from the front to the back.
   typedef struct packed {
      fault_type              fault;
      logic                   direct;
      logic [LEVEL_BITS-1:0]  level;
      logic [SEG_W-1:0]       seg;
      logic [SAMPLE_BITS-1:0] offset;
   } item_type;

   // Level at the lower-sample end of a segment.
   function automatic logic [LEVEL_BITS-1:0] seg_base(input logic [SEG_W-1:0] seg);
      logic [LEVEL_BITS-1:0] r;
      r = ROM_Y[TABLE_POINTS-1];
      for (int k = 0; k < NUM_SEGS; k++) begin
         if (seg == SEG_W'(k)) begin
            r = ROM_Y[k+1];
         end
      end
      return r;
   endfunction

   // True when the level falls from the base toward the upper end of the segment.
   function automatic logic seg_falling(input logic [SEG_W-1:0] seg);
      logic r;
      r = 1'b1;
      for (int k = 0; k < NUM_SEGS; k++) begin
         if (seg == SEG_W'(k)) begin
            r = (ROM_Y[k+1] >= ROM_Y[k]);
         end
      end
      return r;
   endfunction

   // Magnitude of the level step across a segment.
   function automatic logic [LEVEL_BITS-1:0] seg_delta(input logic [SEG_W-1:0] seg);
      logic [LEVEL_BITS-1:0] r;
      r = '0;
      for (int k = 0; k < NUM_SEGS; k++) begin
         if (seg == SEG_W'(k)) begin
            r = (ROM_Y[k+1] >= ROM_Y[k]) ? (ROM_Y[k+1] - ROM_Y[k]) : (ROM_Y[k] - ROM_Y[k+1]);
         end
      end
      return r;
   endfunction

   function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
      logic [RECIP_W-1:0] r;
      r = '0;
      for (int k = 0; k < NUM_SEGS; k++) begin
         if (seg == SEG_W'(k)) begin
            r = SEG_RECIP[k];
         end
      end
      return r;
   endfunction

endpackage

### hw/rtl/sensor_breakpoint_interpolator_top.sv
// A sample taken at one clock edge is written into a queue slot, then passes through three
// pipeline registers (a, b and o stages) before rsp_valid shows its result.
// Throughput: one sample per cycle; the multiply and reciprocal stages are fully pipelined,
// and busy rises only when the front-to-back queue is full, which a free-running back end avoids.
// Reset: limits return to 3300 and 1000, the queue and pipeline empty out; results cannot be held.
// Depends on sbi_pkg, sbi_front, sbi_queue and sbi_back.
module sensor_breakpoint_interpolator_top
   import sbi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [LIMIT_BITS-1:0]  csr_wdata,
   input  logic                   start,
   output logic                   busy,
   input  logic [SAMPLE_BITS-1:0] req_adc_sample,
   output logic                   rsp_valid,
   output logic [LEVEL_BITS-1:0]  rsp_level,
   output logic [1:0]             rsp_fault_code
);

   logic      accept, push, q_valid, q_full;
   item_type  push_item, pop_item;
   fault_type fault;

   assign busy   = q_full;
   assign accept = start && !q_full;

   sbi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sample    (req_adc_sample),
      .push      (push),
      .item      (push_item)
   );

   sbi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_valid),
      .valid     (q_valid),
      .pop_item  (pop_item),
      .full      (q_full)
   );

   sbi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (pop_item),
      .out_valid (rsp_valid),
      .out_level (rsp_level),
      .out_fault (fault)
   );

   assign rsp_fault_code = fault;

endmodule

### hw/rtl/sbi_front.sv
// Front end: limit registers, fault classification and breakpoint segment search.
// Depends on sbi_pkg.
module sbi_front
   import sbi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [LIMIT_BITS-1:0]  csr_wdata,
   input  logic                   accept,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic                   push,
   output item_type               item
);

   logic [LIMIT_BITS-1:0] high_limit_ff, high_limit_in;
   logic [LIMIT_BITS-1:0] low_limit_ff, low_limit_in;
   logic [NUM_SEGS-1:0]   hit;

   always_comb begin
      high_limit_in = high_limit_ff;
      low_limit_in  = low_limit_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAULT_HIGH_LIMIT: high_limit_in = csr_wdata;
            CSR_FAULT_LOW_LIMIT:  low_limit_in  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff <= HIGH_LIMIT_RESET;
         low_limit_ff  <= LOW_LIMIT_RESET;
      end else begin
         high_limit_ff <= high_limit_in;
         low_limit_ff  <= low_limit_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_SEGS; k++) begin
         hit[k] = (sample <= ROM_X[k]) && (sample > ROM_X[k+1]);
      end
   end

   // The segment's upper breakpoint gives an offset equal to the span, which
   // makes an exact hit come out as the stored level without a special case.
   always_comb begin
      item.fault  = FAULT_NONE;
      item.direct = 1'b0;
      item.level  = ROM_Y[TABLE_POINTS-1];
      item.seg    = '0;
      item.offset = '0;
      for (int k = NUM_SEGS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            item.seg    = SEG_W'(k);
            item.offset = sample - ROM_X[k+1];
         end
      end
      priority if (sample > high_limit_ff) begin
         item.fault  = FAULT_SHORT_HIGH;
         item.direct = 1'b1;
         item.level  = LEVEL_FULL;
      end else if (sample < low_limit_ff) begin
         item.fault  = FAULT_SHORT_LOW;
         item.direct = 1'b1;
         item.level  = LEVEL_EMPTY;
      end else if (sample >= ROM_X[0]) begin
         item.direct = 1'b1;
         item.level  = ROM_Y[0];
      end else if (!(|hit)) begin
         item.direct = 1'b1;
      end else begin
         item.direct = 1'b0;
      end
   end

   assign push = accept;

endmodule

### hw/rtl/sbi_queue.sv
// Short FIFO of classified words between the front end and the interpolation pipeline.
// Depends on sbi_pkg.
module sbi_queue
   import sbi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     valid,
   output item_type pop_item,
   output logic     full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign valid    = (count_ff != '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/sbi_back.sv
// Interpolation pipeline: step times offset, reciprocal scaling, then the final level.
// Depends on sbi_pkg.
module sbi_back
   import sbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  item_type              in_item,
   output logic                  out_valid,
   output logic [LEVEL_BITS-1:0] out_level,
   output fault_type             out_fault
);

   typedef struct packed {
      fault_type             fault;
      logic                  direct;
      logic [LEVEL_BITS-1:0] level;
      logic [SEG_W-1:0]      seg;
   } tag_type;

   logic                  a_valid_ff, b_valid_ff, o_valid_ff;
   tag_type               a_tag_ff, a_tag_in, b_tag_ff;
   logic [PROD_W-1:0]     a_prod_ff, a_prod_in;
   logic [SCALED_W-1:0]   scaled;
   logic [LEVEL_BITS-1:0] b_quot_ff, b_quot_in;
   logic [LEVEL_BITS-1:0] o_level_ff, o_level_in;
   fault_type             o_fault_ff;

   always_comb begin
      a_tag_in.fault  = in_item.fault;
      a_tag_in.direct = in_item.direct;
      a_tag_in.level  = in_item.level;
      a_tag_in.seg    = in_item.seg;
      a_prod_in = PROD_W'(seg_delta(in_item.seg)) * PROD_W'(in_item.offset);
   end

   // Multiplying by the rounded-up reciprocal gives the exact floor quotient.
   assign scaled    = SCALED_W'(a_prod_ff) * SCALED_W'(seg_recip(a_tag_ff.seg));
   assign b_quot_in = scaled[RECIP_SHIFT +: LEVEL_BITS];

   always_comb begin
      if (b_tag_ff.direct) begin
         o_level_in = b_tag_ff.level;
      end else if (seg_falling(b_tag_ff.seg)) begin
         o_level_in = seg_base(b_tag_ff.seg) - b_quot_ff;
      end else begin
         o_level_in = seg_base(b_tag_ff.seg) + b_quot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         o_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_tag_ff   <= a_tag_in;
      a_prod_ff  <= a_prod_in;
      b_tag_ff   <= a_tag_ff;
      b_quot_ff  <= b_quot_in;
      o_level_ff <= o_level_in;
      o_fault_ff <= b_tag_ff.fault;
   end

   assign out_valid = o_valid_ff;
   assign out_level = o_level_ff;
   assign out_fault = o_fault_ff;

endmodule
